### hdl/llt_pkg.sv
// Shared request codes, result status codes and controller interface types for the live list.
package llt_pkg;

	// Request kinds carried on the mode field.
	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_FIND   = 3'd2;
	localparam logic [2:0] MODE_SEEN   = 3'd3;
	localparam logic [2:0] MODE_TOKEN  = 3'd4;

	// Width of the entry count reported with every result.
	localparam int ENTRY_W = 6;

	// Reset values of the permanent address window.
	localparam logic [7:0] PERM_MIN_RST = 8'd20;
	localparam logic [7:0] PERM_MAX_RST = 8'd247;

	// Configuration register indexes.
	localparam logic CFG_PERM_MIN = 1'b0;
	localparam logic CFG_PERM_MAX = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} llt_status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        load;       // latch a new request and clear the walk
		logic        walk;       // issue the next entry read
		logic        seek;       // record a match and aim the walk just past it
		logic        shift;      // write each returned entry one place lower
		logic        wr_class;   // update the class of the matched entry
		logic        wr_seen;    // update the last-seen time of the matched entry
		logic        append;     // write a new entry at the end of the list
		logic        dec;        // drop one entry from the count
		logic        ptr_sub;    // one reduction step of the token pointer
		logic        tok_read;   // read the entry under the token pointer
		logic        tok_grant;  // take the granted address and advance the pointer
		logic        finish;     // register the result and strobe it
		llt_status_t status;
	} llt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] mode;
		logic       range_ok;
		logic       match;
		logic       exhausted;
		logic       hit;
		logic       full;
		logic       count_zero;
		logic       ptr_ge;
	} llt_stat_t;

endpackage

### hdl/live_list_token_table.sv
// Top level of the live list and round-robin token table.
//
// A request is transferred on a rising edge where start is high and busy is low; mode, address,
// station_kind and timestamp are sampled on that edge. Busy stays high until the request is
// finished, so one request is in work at a time. Its single result is shown on status, found,
// token_address, entry_count and list_full for exactly one cycle, marked by done. The receiver
// cannot stall; it must take the result in that cycle. A new start is accepted in the very
// cycle that done is high.
// The permanent address window is written through cfg_valid, cfg_ready, cfg_index and cfg_data;
// cfg_ready is always high and a write takes effect on the transfer edge.
// The walk over the station memory reads one entry per cycle through its single registered read
// port. Add, find and mark seen walk until a match or the end of the list; removing a listed entry
// then moves the later entries down one place and drops one from the count. Next token first
// subtracts the count from the pointer until it is below the count after removals, then reads
// the entry under it. Out-of-range adds, empty token requests and unused mode codes go from
// decode straight to the result.
// Reset clears the count, the token pointer and the controller and restores the window to its
// reset values; station entries are left as they are and are only read once written.
module live_list_token_table #(
	parameter int MAX_DEVICES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [7:0]  address,
	input  logic [7:0]  station_kind,
	input  logic [31:0] timestamp,
	output logic        done,
	output logic [1:0]  status,
	output logic        found,
	output logic [7:0]  token_address,
	output logic [llt_pkg::ENTRY_W-1:0] entry_count,
	output logic        list_full,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import llt_pkg::*;

	llt_cmd_t  cmd;
	llt_stat_t stat;
	logic      cfg_we;

	// Configuration registers always take a write.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// The controller decides the sequence; the datapath owns all storage and arithmetic.
	llt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	llt_dpath #(
		.MAX_DEVICES (MAX_DEVICES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.address       (address),
		.station_kind  (station_kind),
		.timestamp     (timestamp),
		.cmd           (cmd),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.found         (found),
		.token_address (token_address),
		.entry_count   (entry_count),
		.list_full     (list_full)
	);

	// A transferred request keeps the block busy on the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request transfer did not make the block busy");

	// Every result comes from a separate request that must pass the decode and finish states.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// A full rejection is only reported with a full list.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL) |-> list_full)
		else $error("list full status reported with room in the list");

endmodule

### hdl/llt_ctrl.sv
// Controller state machine that sequences each live list request.
module llt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  llt_pkg::llt_stat_t stat,
	output llt_pkg::llt_cmd_t  cmd
);
	import llt_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_SCAN   = 8'b0000_0100,
		S_ACT    = 8'b0000_1000,
		S_SHIFT  = 8'b0001_0000,
		S_MODP   = 8'b0010_0000,
		S_TWAIT  = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} llt_state_t;

	llt_state_t  state_q, state_d;
	llt_status_t st_q, st_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		st_d       = st_q;
		cmd        = '0;
		cmd.status = st_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					st_d     = ST_OK;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.mode) inside
					MODE_ADD: begin
						if (!stat.range_ok) begin
							st_d    = ST_RANGE;
							state_d = S_FIN;
						end else begin
							state_d = S_SCAN;
						end
					end
					MODE_REMOVE, MODE_FIND, MODE_SEEN: state_d = S_SCAN;
					MODE_TOKEN: state_d = stat.count_zero ? S_FIN : S_MODP;
					default: state_d = S_FIN;
				endcase
			end
			S_SCAN: begin
				if (stat.match) begin
					cmd.seek = 1'b1;
					state_d  = S_ACT;
				end else if (stat.exhausted) begin
					state_d = S_ACT;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			S_ACT: begin
				state_d = S_FIN;
				unique case (stat.mode) inside
					MODE_ADD: begin
						if (stat.hit) begin
							cmd.wr_class = 1'b1;
						end else if (stat.full) begin
							st_d = ST_FULL;
						end else begin
							cmd.append = 1'b1;
						end
					end
					MODE_REMOVE: begin
						if (stat.hit) begin
							state_d = S_SHIFT;
						end else begin
							st_d = ST_NOT_FOUND;
						end
					end
					MODE_SEEN: begin
						if (stat.hit) begin
							cmd.wr_seen = 1'b1;
						end else begin
							st_d = ST_NOT_FOUND;
						end
					end
					default: st_d = st_q;
				endcase
			end
			S_SHIFT: begin
				if (stat.exhausted) begin
					cmd.dec = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.walk  = 1'b1;
					cmd.shift = 1'b1;
				end
			end
			S_MODP: begin
				if (stat.ptr_ge) begin
					cmd.ptr_sub = 1'b1;
				end else begin
					cmd.tok_read = 1'b1;
					state_d      = S_TWAIT;
				end
			end
			S_TWAIT: begin
				cmd.tok_grant = 1'b1;
				state_d       = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

endmodule

### hdl/llt_dpath.sv
// Datapath with the station memories, walk pipeline, token pointer and result registers.
module llt_dpath #(
	parameter int MAX_DEVICES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic [2:0]         mode,
	input  logic [7:0]         address,
	input  logic [7:0]         station_kind,
	input  logic [31:0]        timestamp,
	input  llt_pkg::llt_cmd_t  cmd,
	output llt_pkg::llt_stat_t stat,
	output logic               done,
	output logic [1:0]         status,
	output logic               found,
	output logic [7:0]         token_address,
	output logic [llt_pkg::ENTRY_W-1:0] entry_count,
	output logic               list_full
);
	import llt_pkg::*;

	localparam int CNT_W = $clog2(MAX_DEVICES + 1);
	localparam int IDX_W = $clog2(MAX_DEVICES);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DEVICES);

	logic [7:0]  perm_min_q, perm_max_q;
	logic [2:0]  req_mode_q;
	logic [7:0]  req_addr_q, req_class_q;
	logic [31:0] req_stamp_q;

	logic [CNT_W-1:0] count_q, scan_q, rd_idx_s1;
	logic [IDX_W-1:0] ptr_q, hit_idx_q;
	logic             rd_v_s1, hit_q;
	logic [7:0]       tok_q;

	// Station storage, one array per field, sharing one read and one write address.
	logic [7:0]  addr_mem  [MAX_DEVICES];
	logic [7:0]  class_mem [MAX_DEVICES];
	logic [31:0] seen_mem  [MAX_DEVICES];
	logic [7:0]  addr_rd_q, class_rd_q;
	logic [31:0] seen_rd_q;

	logic             issue, rd_en, shift_we;
	logic [IDX_W-1:0] rd_idx, wr_idx;
	logic             addr_we, class_we, seen_we;
	logic [7:0]       wr_addr, wr_class;
	logic [31:0]      wr_seen;
	logic [CNT_W-1:0] ptr_ext, ptr_inc;

	logic                   done_q, found_q, full_q;
	llt_status_t            status_q;
	logic [7:0]             token_q;
	logic [ENTRY_W-1:0]     count_out_q;
	logic [ENTRY_W+CNT_W-1:0] count_wide;

	assign issue    = cmd.walk && (scan_q < count_q);
	assign rd_en    = issue || cmd.tok_read;
	assign rd_idx   = cmd.tok_read ? ptr_q : IDX_W'(scan_q);
	assign shift_we = cmd.shift && rd_v_s1;
	assign ptr_ext  = CNT_W'(ptr_q);
	assign ptr_inc  = ptr_ext + CNT_W'(1);

	always_comb begin
		if (shift_we) begin
			wr_idx = IDX_W'(rd_idx_s1 - CNT_W'(1));
		end else if (cmd.append) begin
			wr_idx = IDX_W'(count_q);
		end else begin
			wr_idx = hit_idx_q;
		end
		addr_we  = shift_we || cmd.append;
		class_we = shift_we || cmd.append || cmd.wr_class;
		seen_we  = shift_we || cmd.append || cmd.wr_seen;
		wr_addr  = shift_we ? addr_rd_q : req_addr_q;
		wr_class = shift_we ? class_rd_q : req_class_q;
		if (shift_we) begin
			wr_seen = seen_rd_q;
		end else if (cmd.append) begin
			wr_seen = '0;
		end else begin
			wr_seen = req_stamp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (addr_we) begin
			addr_mem[wr_idx] <= wr_addr;
		end
		if (class_we) begin
			class_mem[wr_idx] <= wr_class;
		end
		if (seen_we) begin
			seen_mem[wr_idx] <= wr_seen;
		end
		if (rd_en) begin
			addr_rd_q  <= addr_mem[rd_idx];
			class_rd_q <= class_mem[rd_idx];
			seen_rd_q  <= seen_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_mode_q  <= mode;
			req_addr_q  <= address;
			req_class_q <= station_kind;
			req_stamp_q <= timestamp;
		end
		if (issue) begin
			rd_idx_s1 <= scan_q;
		end
		if (cmd.seek) begin
			hit_idx_q <= IDX_W'(rd_idx_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_min_q <= PERM_MIN_RST;
			perm_max_q <= PERM_MAX_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_PERM_MIN) begin
				perm_min_q <= cfg_data;
			end else begin
				perm_max_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			scan_q  <= '0;
			rd_v_s1 <= 1'b0;
			hit_q   <= 1'b0;
			tok_q   <= '0;
		end else begin
			rd_v_s1 <= issue;
			if (cmd.load) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				tok_q  <= '0;
			end else if (cmd.seek) begin
				scan_q <= rd_idx_s1 + CNT_W'(1);
				hit_q  <= 1'b1;
			end else if (issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.ptr_sub) begin
				ptr_q <= IDX_W'(ptr_ext - count_q);
			end else if (cmd.tok_grant) begin
				ptr_q <= (ptr_inc == count_q) ? '0 : IDX_W'(ptr_inc);
			end
			if (cmd.tok_grant) begin
				tok_q <= addr_rd_q;
			end
		end
	end

	assign count_wide = {{ENTRY_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q    <= cmd.status;
			found_q     <= (req_mode_q == MODE_FIND) && hit_q;
			token_q     <= tok_q;
			count_out_q <= count_wide[ENTRY_W-1:0];
			full_q      <= (count_q >= MAX_CNT);
		end
	end

	assign stat.mode       = req_mode_q;
	assign stat.range_ok   = (req_addr_q >= perm_min_q) && (req_addr_q <= perm_max_q);
	assign stat.match      = rd_v_s1 && (addr_rd_q == req_addr_q);
	assign stat.exhausted  = !rd_v_s1 && (scan_q >= count_q);
	assign stat.hit        = hit_q;
	assign stat.full       = (count_q >= MAX_CNT);
	assign stat.count_zero = (count_q == '0);
	assign stat.ptr_ge     = (ptr_ext >= count_q);

	assign done          = done_q;
	assign status        = status_q;
	assign found         = found_q;
	assign token_address = token_q;
	assign entry_count   = count_out_q;
	assign list_full     = full_q;

endmodule
